// ===== sv/rgbmono_pkg.sv =====
// Shared types, constants and functions of the RGB565 to mono converter.
package rgbmono_pkg;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam int ERR_W = 10;
	localparam int BIDX_W = 10;

	localparam logic [CFG_ADDR_W-1:0] REG_DITHER_ENABLE = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GRAY_THRESHOLD = 1'd1;

	localparam logic [7:0] GRAY_THRESHOLD_RST = 8'd128;
	localparam logic [7:0] WHITE_LEVEL = 8'd255;

	// Per-pixel context handed from the stream control to the diffusion unit.
	typedef struct packed {
		logic [7:0] gray;
		logic       col_first;
		logic       col_last;
		logic       row_first;
	} pix_ctx_t;

	// Gray level (21*R + 42*G + 11*B) >> 2, saturated at full white.
	function automatic logic [7:0] rgb565_gray(input logic [15:0] pix);
		logic [11:0] sum;
		sum = 12'(pix[15:11]) * 12'd21 + 12'(pix[10:5]) * 12'd42 + 12'(pix[4:0]) * 12'd11;
		if (sum[11:10] != 2'b00) begin
			return WHITE_LEVEL;
		end
		return sum[9:2];
	endfunction

	// Signed division by sixteen, rounding toward zero.
	function automatic logic [ERR_W-1:0] div16(input logic signed [11:0] v);
		logic signed [11:0] adj;
		adj = v[11] ? (v + 12'sd15) : v;
		return {{(ERR_W-8){adj[11]}}, adj[11:4]};
	endfunction

endpackage

// ===== sv/rgbmono_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rgbmono_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rgbmono_fs.sv =====
// Floyd-Steinberg error diffusion step with its short feedback registers.
module rgbmono_fs
	import rgbmono_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  pix_ctx_t         ctx,
	input  logic             dither_enable,
	input  logic [7:0]       gray_threshold,
	input  logic [ERR_W-1:0] row_rdata,
	output logic             white,
	output logic [ERR_W-1:0] row_wdata
);

	// c7_q: right-hand share of the previous pixel. c1_q: its below-right share.
	// part_q: partial sum for the next-row entry under the current pixel.
	// tail_q: the next-row entry under the last column, which has no RAM slot.
	logic [ERR_W-1:0] c7_q, c1_q, part_q, tail_q;

	logic [ERR_W-1:0]   cur_base, cur_err, part_next;
	logic signed [10:0] corr;
	logic [7:0]         corr_c, level;
	logic signed [8:0]  err;
	logic signed [11:0] err_x, e7, e5, e3;
	logic [ERR_W-1:0]   c7, c5, c3, c1;

	always_comb begin
		cur_base = ctx.row_first ? '0 : (ctx.col_last ? tail_q : row_rdata);
		cur_err = cur_base + (ctx.col_first ? '0 : c7_q);
		corr = signed'({3'b000, ctx.gray}) + signed'({cur_err[ERR_W-1], cur_err});
		if (corr[10]) begin
			corr_c = 8'd0;
		end else if (corr[9:8] != 2'b00) begin
			corr_c = WHITE_LEVEL;
		end else begin
			corr_c = corr[7:0];
		end
		level = dither_enable ? corr_c : ctx.gray;
		white = (level >= gray_threshold);
		// With dithering off nothing is diffused.
		err = dither_enable ? (signed'({1'b0, corr_c}) - (white ? 9'sd255 : 9'sd0)) : 9'sd0;
		err_x = {{3{err[8]}}, err};
		e7 = err_x * 12'sd7;
		e5 = err_x * 12'sd5;
		e3 = err_x * 12'sd3;
		c7 = div16(e7);
		c5 = div16(e5);
		c3 = div16(e3);
		c1 = div16(err_x);
		row_wdata = (ctx.col_first ? '0 : part_q) + c3;
		part_next = (ctx.col_first ? '0 : c1_q) + c5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c7_q <= '0;
			c1_q <= '0;
			part_q <= '0;
			tail_q <= '0;
		end else if (advance) begin
			c7_q <= c7;
			c1_q <= c1;
			part_q <= part_next;
			if (ctx.col_last) begin
				tail_q <= part_next;
			end
		end
	end

endmodule

// ===== sv/rgb565_to_mono_dither_pack_top.sv =====
// RGB565 to monochrome converter with optional error diffusion and XBM byte packing.
//
// Takes one RGB565 pixel per clock in raster order, unless a low m_tready holds
// the output, and returns one XBM byte (eight pixels, leftmost in bit 0) with
// its position after every eighth pixel and at the end of each row; tlast marks
// the last byte of the frame. A pixel waits in the input register and a finished
// byte is then written to the result register. Neither the error feedback to the
// right neighbor, which closes through one register, nor the error row of the
// line below, kept in a RAM of IMAGE_WIDTH words read one column ahead, slows
// the input. No clearing pass is needed after reset: the first row of each frame
// ignores the stored errors and every later row reads only what the row above
// wrote. Configuration should be written only while no pixel is in flight.
module rgb565_to_mono_dither_pack_top
	import rgbmono_pkg::*;
#(
	parameter int IMAGE_WIDTH = 128,
	parameter int IMAGE_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,    // pixel_rgb565
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,    // packed byte, byte position, zero fill
	output logic                  m_tlast,    // frame_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(IMAGE_WIDTH);
	localparam int ROW_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
	localparam int PIX_W = BIDX_W + 3;
	localparam int LAST_PIX = IMAGE_WIDTH * IMAGE_HEIGHT - 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);
	localparam logic [BIDX_W-1:0] LAST_BIDX = BIDX_W'(LAST_PIX / 8);

	// Configuration registers
	logic       dither_q;
	logic [7:0] threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_q <= 1'b0;
			threshold_q <= GRAY_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				REG_DITHER_ENABLE:  dither_q <= cfg_data[0];
				REG_GRAY_THRESHOLD: threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Raster position of the next pixel to be accepted
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] pix_q;
	logic             in_col_last, in_row_last, s_accept;

	assign in_col_last = (col_q == COL_LAST);
	assign in_row_last = (row_q == ROW_LAST);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pix_q <= '0;
		end else if (s_accept) begin
			if (in_col_last) begin
				col_q <= '0;
				row_q <= in_row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
			pix_q <= (in_col_last && in_row_last) ? '0 : pix_q + 1'b1;
		end
	end

	// Input register
	logic              s1_valid;
	pix_ctx_t          ctx_s1;
	logic [COL_W-1:0]  col_s1;
	logic              row_last_s1;
	logic [BIDX_W-1:0] bidx_s1;
	logic              emit_s1, advance;
	logic              m_valid_q;

	assign emit_s1 = (col_s1[2:0] == 3'b111) || ctx_s1.col_last;
	assign advance = s1_valid && (!emit_s1 || !m_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			ctx_s1.gray <= rgb565_gray(s_tdata);
			ctx_s1.col_first <= (col_q == '0);
			ctx_s1.col_last <= in_col_last;
			ctx_s1.row_first <= (row_q == '0);
			col_s1 <= col_q;
			row_last_s1 <= in_row_last;
			bidx_s1 <= pix_q[PIX_W-1:3];
		end
	end

	// Error row of the line below: entry x is written by pixel x and read back
	// one row later while the pixel to its left enters.
	logic [COL_W-1:0] ram_raddr;
	logic [ERR_W-1:0] ram_rdata, ram_wdata;
	logic             white;

	assign ram_raddr = in_col_last ? '0 : col_q + 1'b1;

	rgbmono_ram #(
		.WIDTH(ERR_W),
		.DEPTH(IMAGE_WIDTH)
	) u_err_row (
		.clk  (clk),
		.we   (advance),
		.waddr(col_s1),
		.wdata(ram_wdata),
		.re   (s_accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rgbmono_fs u_fs (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.ctx           (ctx_s1),
		.dither_enable (dither_q),
		.gray_threshold(threshold_q),
		.row_rdata     (ram_rdata),
		.white         (white),
		.row_wdata     (ram_wdata)
	);

	// Bit packing and result register
	logic [7:0]        bits_q, bits_next;
	logic [7:0]        packed_q;
	logic [BIDX_W-1:0] bidx_q;
	logic              last_q;

	assign bits_next = bits_q | (8'(white) << col_s1[2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				bits_q <= emit_s1 ? '0 : bits_next;
			end
			if (advance && emit_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_s1) begin
			packed_q <= bits_next;
			bidx_q <= bidx_s1;
			last_q <= ctx_s1.col_last && row_last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {6'b0, bidx_q, packed_q};
	assign m_tlast = last_q;

`ifndef SYNTH
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && in_col_last && in_row_last |=> col_q == '0 && row_q == '0 && pix_q == '0)
		else $error("raster counters did not return to zero after the last pixel");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[17:8] == LAST_BIDX)
		else $error("frame end word carries the wrong byte index");

	a_ram_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && advance |-> ram_raddr != col_s1)
		else $error("error row read and write hit the same entry");

	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input stalled while the result register is empty");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the RGB565 to mono converter with dithering and byte packing.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbmono_pkg::*;

	localparam int IMAGE_WIDTH = 128;
	localparam int IMAGE_HEIGHT = 64;
	localparam int ROW_SLOTS = IMAGE_WIDTH + 2;
	localparam int CLK_PERIOD = 12;
	localparam int TOTAL_PIXELS = 1600;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_CYCLES = 1_000_000;

	typedef struct packed {
		logic [7:0]        bits;
		logic [BIDX_W-1:0] idx;
		logic              frame_end;
	} mono_byte_t;

	typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		logic [CFG_ADDR_W-1:0] addr;
		logic [15:0]           value;
		logic                  typed;
		mono_byte_t            want;
	} plan_row_t;

	localparam mono_byte_t NO_BYTE = '0;

	// Directed part: pixel extremes and gray overflow under the reset threshold and
	// the threshold extremes, then a switch to diffusion in the middle of the first row.
	plan_row_t plan [36] = '{
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'hFFFF, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'hF800, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h07E0, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h001F, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0148, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'hFFFF, 1'b1, '{8'hAE, 10'd0, 1'b0}},
		'{STEP_REG, REG_GRAY_THRESHOLD, 16'd0, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b1, '{8'hFF, 10'd1, 1'b0}},
		'{STEP_REG, REG_GRAY_THRESHOLD, 16'd255, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'hFFFF, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'hF800, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h07E0, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h001F, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'hFFFE, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h0000, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h07E0, 1'b1, '{8'h95, 10'd2, 1'b0}},
		'{STEP_REG, REG_DITHER_ENABLE, 16'd1, 1'b0, NO_BYTE},
		'{STEP_REG, REG_GRAY_THRESHOLD, 16'd128, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE},
		'{STEP_PIXEL, '0, 16'h1161, 1'b0, NO_BYTE}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the converter state.
	logic signed [ERR_W-1:0] err_rows [2][ROW_SLOTS];
	int                      col_cnt;
	int                      row_cnt;
	logic [7:0]              collector;
	bit                      dither_on;
	logic [7:0]              threshold;

	mono_byte_t pending_bytes [$];
	int         mismatches;
	int         burst_left;
	int         pixels_sent;
	int         rx_mode;
	int         rx_left;
	int         rx_phase;

	rgb565_to_mono_dither_pack_top #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	task automatic clear_err_row(input int row);
		for (int i = 0; i < ROW_SLOTS; i++) begin
			err_rows[row][i] = '0;
		end
	endtask

	task automatic spread_err(input int row, input int idx, input int amount);
		if (idx < ROW_SLOTS) begin
			err_rows[row][idx] = ERR_W'(int'(err_rows[row][idx]) + amount);
		end
	endtask

	// Turns one pixel into a mono bit and returns the packed byte when one is complete.
	task automatic dither_pixel(input logic [15:0] pix, output bit emitted,
			output mono_byte_t res);
		int gray;
		int corr;
		int err_val;
		int x;
		int y;
		int cur;
		int nxt;
		bit white;
		bit last_col;
		bit last_row;
		gray = (int'(pix[15:11]) * 21 + int'(pix[10:5]) * 42 + int'(pix[4:0]) * 11) >> 2;
		if (gray > 255) begin
			gray = 255;
		end
		x = col_cnt;
		y = row_cnt;
		cur = y % 2;
		nxt = 1 - cur;
		if (x == 0) begin
			if (y == 0) begin
				clear_err_row(0);
				clear_err_row(1);
			end else begin
				clear_err_row(nxt);
			end
		end
		if (dither_on) begin
			corr = gray;
			if (x + 1 < ROW_SLOTS) begin
				corr += int'(err_rows[cur][x + 1]);
			end
			if (corr < 0) begin
				corr = 0;
			end
			if (corr > 255) begin
				corr = 255;
			end
			white = corr >= int'(threshold);
			err_val = corr - (white ? 255 : 0);
			// Integer division truncates toward zero, as the shares require.
			spread_err(cur, x + 2, (err_val * 7) / 16);
			spread_err(nxt, x, (err_val * 3) / 16);
			spread_err(nxt, x + 1, (err_val * 5) / 16);
			spread_err(nxt, x + 2, err_val / 16);
		end else begin
			white = gray >= int'(threshold);
		end
		if (white) begin
			collector[x % 8] = 1'b1;
		end
		last_col = x + 1 >= IMAGE_WIDTH;
		last_row = y + 1 >= IMAGE_HEIGHT;
		emitted = (x % 8 == 7) || last_col;
		res = NO_BYTE;
		if (emitted) begin
			res.bits = collector;
			res.idx = BIDX_W'((y * IMAGE_WIDTH + x) >> 3);
			res.frame_end = last_col && last_row;
			collector = '0;
		end
		if (last_col) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : y + 1;
		end else begin
			col_cnt = x + 1;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_pixel(input logic [15:0] pix, input bit typed, input mono_byte_t want);
		bit emitted;
		mono_byte_t res;
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		dither_pixel(pix, emitted, res);
		if (emitted) begin
			pending_bytes.push_back(typed ? want : res);
		end
		pixels_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (addr == REG_DITHER_ENABLE) begin
			dither_on = data[0];
		end else begin
			threshold = data;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stops the pixel stream until every byte has come and the pipeline has emptied.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] make_pixel(input int style, input int level);
		int g;
		case (style)
			0: return 16'($urandom);
			1: begin
				// Dark smooth shades; the brightest of them can still reach gray saturation.
				g = level + $urandom_range(0, 2);
				return {5'($urandom_range(0, 7)), 6'(g), 5'($urandom_range(0, 7))};
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'hF800;
					3: return 16'h07E0;
					4: return 16'h001F;
					default: return 16'($urandom);
				endcase
			end
		endcase
	endfunction

	always @(posedge clk) begin
		mono_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected byte", int'(m_tdata), 0);
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata[7:0] !== want.bits) begin
					report_mismatch("packed_byte", int'(m_tdata[7:0]), int'(want.bits));
				end
				if (m_tdata[8 +: BIDX_W] !== want.idx) begin
					report_mismatch("byte position", int'(m_tdata[8 +: BIDX_W]),
						int'(want.idx));
				end
				if (m_tlast !== want.frame_end) begin
					report_mismatch("frame_end", int'(m_tlast), int'(want.frame_end));
				end
			end
		end
	end

	// The receiver switches between stretches of full speed, random, sparse and
	// periodic acceptance.
	always @(negedge clk) begin
		if (rx_left <= 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 256);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= (rx_phase % 5) < 3;
		endcase
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL");
		$finish;
	end

	initial begin
		int style;
		int level;
		int len;
		logic [CFG_DATA_W-1:0] thr;
		clear_err_row(0);
		clear_err_row(1);
		col_cnt = 0;
		row_cnt = 0;
		collector = '0;
		dither_on = 1'b0;
		threshold = GRAY_THRESHOLD_RST;
		mismatches = 0;
		burst_left = 0;
		pixels_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG) begin
				wait_idle();
				write_reg(plan[i].addr, plan[i].value[CFG_DATA_W-1:0]);
			end else begin
				send_pixel(plan[i].value, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each under a fresh setting; a phase boundary stops the
		// sender until every byte is back.
		while (pixels_sent < TOTAL_PIXELS) begin
			wait_idle();
			write_reg(REG_DITHER_ENABLE, CFG_DATA_W'($urandom_range(0, 3) != 0));
			case ($urandom_range(0, 4))
				0: thr = 8'd0;
				1: thr = 8'd255;
				2: thr = GRAY_THRESHOLD_RST;
				default: thr = 8'($urandom);
			endcase
			write_reg(REG_GRAY_THRESHOLD, thr);
			style = $urandom_range(0, 2);
			level = $urandom_range(0, 24);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(100, 700);
			if (len > TOTAL_PIXELS - pixels_sent) begin
				len = TOTAL_PIXELS - pixels_sent;
			end
			repeat (len) send_pixel(make_pixel(style, level), 1'b0, NO_BYTE);
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
